// ===== rtl/dbmd_pkg.sv =====
// shared constants, result struct and byte-lane helper for the message deframer
package dbmd_pkg;

  localparam int unsigned CapWidth   = 28;
  localparam int unsigned LenWidth   = 32;
  localparam logic [CapWidth-1:0] CapDefault = 28'd134217728;
  localparam logic [CapWidth-1:0] HdrFixed   = 28'd16;
  localparam logic [CapWidth-1:0] HdrAlign   = 28'd8;
  localparam logic [7:0] BeMark = 8'h42;

  // header byte offsets
  localparam logic [CapWidth-1:0] PosBodyLo   = 28'd4;
  localparam logic [CapWidth-1:0] PosBodyHi   = 28'd7;
  localparam logic [CapWidth-1:0] PosFieldsLo = 28'd12;
  localparam logic [CapWidth-1:0] PosHdrEnd   = 28'd15;

  typedef struct packed {
    logic [7:0]          data;
    logic                first;
    logic                last;
    logic [CapWidth-1:0] msg_len;
    logic                invalid;
  } result_t;

  // replace one byte lane of a length word, lane order set by endianness
  function automatic logic [LenWidth-1:0] put_byte(input logic [LenWidth-1:0] word,
                                                   input logic [1:0] idx,
                                                   input logic [7:0] b,
                                                   input logic be);
    logic [1:0]          lane;
    logic [LenWidth-1:0] w;
    lane = be ? ~idx : idx;
    w = word;
    unique case (lane)
      2'd0: w[7:0]   = b;
      2'd1: w[15:8]  = b;
      2'd2: w[23:16] = b;
      2'd3: w[31:24] = b;
      default: w = word;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dbmd_in_stage.sv =====
// input register stage holding one received byte
module dbmd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       out_free,
  output logic       hold_valid,
  output logic [7:0] hold_data,
  output logic       advance
);

  assign advance  = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_data <= in_data;
    end
  end

endmodule

// ===== rtl/dbmd_framer.sv =====
// message framing state and per-byte length logic
module dbmd_framer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dbmd_pkg::CapWidth-1:0] cfg_wdata,
  input  logic                          advance,
  input  logic [7:0]                    data,
  output dbmd_pkg::result_t             result
);

  logic [dbmd_pkg::CapWidth-1:0] size_cap;
  logic [dbmd_pkg::CapWidth-1:0] position;
  logic                          big_endian;
  logic [dbmd_pkg::LenWidth-1:0] body_length;
  logic [dbmd_pkg::LenWidth-1:0] fields_length;
  logic [dbmd_pkg::CapWidth-1:0] total_length;
  logic                          failed;

  logic                          is_first;
  logic                          at_hdr_end;
  logic                          past_hdr;
  logic                          be_next;
  logic [dbmd_pkg::LenWidth-1:0] body_next;
  logic [dbmd_pkg::LenWidth-1:0] fields_next;
  logic                          pos_fail;
  logic                          len_fail;
  logic [dbmd_pkg::CapWidth:0]   hdr_round;
  logic [dbmd_pkg::CapWidth+1:0] tot_sum;
  logic                          tot_fail;
  logic                          failed_next;
  logic [dbmd_pkg::CapWidth-1:0] total_next;
  logic [dbmd_pkg::CapWidth:0]   pos_inc;
  logic                          last;

  always_comb begin
    is_first   = (position == '0);
    at_hdr_end = (position == dbmd_pkg::PosHdrEnd);
    past_hdr   = (position >= dbmd_pkg::PosHdrEnd);
    be_next    = is_first ? (data == dbmd_pkg::BeMark) : big_endian;

    body_next = body_length;
    if (position >= dbmd_pkg::PosBodyLo && position <= dbmd_pkg::PosBodyHi) begin
      body_next = dbmd_pkg::put_byte(body_length, position[1:0], data, be_next);
    end
    fields_next = fields_length;
    if (position >= dbmd_pkg::PosFieldsLo && position <= dbmd_pkg::PosHdrEnd) begin
      fields_next = dbmd_pkg::put_byte(fields_length, position[1:0], data, be_next);
    end

    // byte count check: position + 1 > cap
    pos_fail = (position >= size_cap);
    len_fail = (fields_next > {4'b0, size_cap}) || (body_next > {4'b0, size_cap});

    // fixed header plus fields, rounded up to 8, plus body
    hdr_round = ({1'b0, fields_next[dbmd_pkg::CapWidth-1:0]} + {1'b0, dbmd_pkg::HdrFixed}
                 + {1'b0, dbmd_pkg::HdrAlign} - 29'd1) & ~({1'b0, dbmd_pkg::HdrAlign} - 29'd1);
    tot_sum  = {1'b0, hdr_round} + {2'b0, body_next[dbmd_pkg::CapWidth-1:0]};
    tot_fail = (tot_sum > {2'b0, size_cap});

    failed_next = failed || pos_fail || (at_hdr_end && (len_fail || tot_fail));
    total_next  = at_hdr_end ? tot_sum[dbmd_pkg::CapWidth-1:0] : total_length;
    pos_inc     = {1'b0, position} + 29'd1;
    last        = !failed_next && past_hdr && (pos_inc >= {1'b0, total_next});

    result.data    = data;
    result.first   = is_first && !failed_next;
    result.last    = last;
    result.msg_len = (!failed_next && past_hdr) ? total_next : '0;
    result.invalid = failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cap <= dbmd_pkg::CapDefault;
    end else if (cfg_we) begin
      size_cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      big_endian    <= 1'b0;
      body_length   <= '0;
      fields_length <= '0;
      total_length  <= '0;
      failed        <= 1'b0;
    end else if (advance && !failed) begin
      big_endian <= be_next;
      failed     <= failed_next;
      if (!failed_next) begin
        if (last) begin
          position      <= '0;
          body_length   <= '0;
          fields_length <= '0;
          total_length  <= '0;
        end else begin
          position      <= pos_inc[dbmd_pkg::CapWidth-1:0];
          body_length   <= body_next;
          fields_length <= fields_next;
          total_length  <= total_next;
        end
      end
    end
  end

endmodule

// ===== rtl/dbmd_out_stage.sv =====
// result register driving the outgoing stream
module dbmd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dbmd_pkg::result_t result,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output dbmd_pkg::result_t held
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ===== rtl/dbus_message_deframer.sv =====
// top level of the message stream deframer
//
// usage: raw message bytes enter one per request on the s_axis channel and
// leave unchanged on the m_axis channel, tagged with framing marks. byte 0
// of a message picks the header byte order ('B' is big endian), bytes 4..7
// carry the body length and bytes 12..15 the header-fields length. the
// message total is 16 plus the fields length, rounded up to 8, plus the
// body length; the byte that reaches it leaves with tlast high and the next
// byte starts a new message (tuser[0]). message_length is shown from header
// byte 15 to the end of the message, else 0.
// a fields, body or total length above size_cap, or a byte count above it,
// sets a sticky error (tuser[1]) that stops framing until reset.
// path: a byte accepted sits in the input register, moves to the result
// register when that is free and is offered on m_axis from there.
// throughput: one byte per cycle while m_axis_tready is high (single pass of capture and compare).
// reset: clears the byte position, captured lengths, error flag and both
// stage valids; size_cap returns to 128 MiB.
// stall: with m_axis_tready low the result register holds and the input
// register still takes one more request before s_axis_tready drops.
// cfg_we/cfg_wdata write size_cap; write only while the block is idle.
module dbus_message_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dbmd_pkg::CapWidth-1:0] cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // [7:0] out_byte, [35:8] message_length, rest 0
  output logic                          m_axis_tlast,   // last_of_message
  output logic [1:0]                    m_axis_tuser    // [0] first_of_message, [1] frame_error
);

  logic              out_free;
  logic              hold_valid;
  logic [7:0]        hold_data;
  logic              advance;
  dbmd_pkg::result_t result;
  dbmd_pkg::result_t held;

  // input register: takes a request whenever it is empty or the byte held can move on
  dbmd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_free   (out_free),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .advance    (advance)
  );

  // framing state advances once per byte moved to the result register, until an error is flagged
  dbmd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .data      (hold_data),
    .result    (result)
  );

  dbmd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .held      (held)
  );

  // pack result fields onto the stream
  assign m_axis_tdata = {4'b0, held.msg_len, held.data};
  assign m_axis_tlast = held.last;
  assign m_axis_tuser = {held.invalid, held.first};

endmodule

// ===== rtl/dbmd_checker.sv =====
// port-level checks on the deframer output stream, bound to the top level
module dbmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // a stalled request keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // error flag is sticky
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |=> !m_axis_tvalid || m_axis_tuser[1])
    else $error("invalid flag dropped before reset");

  // errored bytes carry no framing
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tlast && !m_axis_tuser[0]
      && (m_axis_tdata[35:8] == 28'd0))
    else $error("framing marks on an errored byte");

  // a message is at least a full fixed header long
  a_last_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[35:8] >= 28'd16) && !m_axis_tuser[0])
    else $error("message end with impossible length");

endmodule

bind dbus_message_deframer dbmd_checker u_dbmd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
